[hw/rtl/scp_pkg.sv]
package scp_pkg;

    localparam int ADDR_W        = 32;
    localparam int DEGREE_W      = 5;
    localparam int LINE_W        = 17;
    localparam int COUNT_W       = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = LINE_W;

    localparam int HISTORY_DEPTH = 64;
    localparam int MAX_DEGREE    = 16;
    localparam int CORR_LIMIT    = 2;
    localparam int FOUND_W       = $clog2(CORR_LIMIT + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEGREE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LINE   = 1'b1;

    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 5'd0;
    localparam logic [LINE_W-1:0]   LINE_RESET   = 17'd64;

endpackage

[hw/rtl/scp_acc_if.sv]
interface scp_acc_if;
    logic                          valid;
    logic                          ready;
    logic [scp_pkg::ADDR_W-1:0]    access_address;
    logic                          was_miss;

    modport source(output valid, output access_address, output was_miss, input ready);
    modport sink(input valid, input access_address, input was_miss, output ready);
endinterface

[hw/rtl/scp_pf_if.sv]
interface scp_pf_if;
    logic                          valid;
    logic                          ready;
    logic [scp_pkg::ADDR_W-1:0]    prefetch_address;
    logic                          last_of_run;
    logic [scp_pkg::COUNT_W-1:0]   issued_count;

    modport source(output valid, output prefetch_address, output last_of_run,
                   output issued_count, input ready);
    modport sink(input valid, input prefetch_address, input last_of_run,
                 input issued_count, output ready);
endinterface

[hw/rtl/sequential_correlation_prefetcher.sv]
// channel   dir  payload                                          transaction
// i_acc     in   access_address[31:0], was_miss                   valid & ready
// o_pf      out  prefetch_address[31:0], last_of_run, issued_count valid & ready
// i_cfg     in   i_cfg_idx, i_cfg_data                            i_cfg_we
//
// one access at a time: an accept state, a history walk over at most fill entries
// (one read a cycle from the history memory, read data registered, ends early after
// two correlation hits), then one prefetch a cycle while o_pf is not stalled (degree + hits).
// reset sets config to its defaults and clears history fill count and head; no clearing pass.
// a stalled o_pf holds its output register; i_acc is ready only between accesses.
module sequential_correlation_prefetcher #(
    parameter int HISTORY_DEPTH = scp_pkg::HISTORY_DEPTH,
    parameter int MAX_DEGREE    = scp_pkg::MAX_DEGREE
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    scp_acc_if.sink                            i_acc,
    scp_pf_if.source                           o_pf,
    input  logic                               i_cfg_we,
    input  logic [scp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW  = scp_pkg::ADDR_W;
    localparam int PW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW  = $clog2(HISTORY_DEPTH + 1);
    localparam int DW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE + 1) : 1;
    localparam int CW  = $clog2(MAX_DEGREE + scp_pkg::CORR_LIMIT + 1);
    localparam int NW  = scp_pkg::FOUND_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

    t_state                         r_state;
    logic [scp_pkg::DEGREE_W-1:0]   r_cfg_degree;
    logic [scp_pkg::LINE_W-1:0]     r_cfg_line;

    logic [AW:0]                    r_mem [HISTORY_DEPTH];
    logic [AW:0]                    r_rd_data;

    logic [PW-1:0]                  r_head;
    logic [FW-1:0]                  r_fill;
    logic [PW-1:0]                  r_rd_ptr;
    logic [FW-1:0]                  r_rd_cnt;
    logic                           r_dv;

    logic [AW-1:0]                  r_addr;
    logic                           r_miss;
    logic [DW-1:0]                  r_deg;
    logic [AW-1:0]                  r_seq;

    logic                           r_follow_ok;
    logic [AW-1:0]                  r_follow;
    logic                           r_prev_ok;
    logic [AW-1:0]                  r_prev;
    logic [NW-1:0]                  r_found;
    logic [AW-1:0]                  r_corr0;
    logic [AW-1:0]                  r_corr1;

    logic [CW-1:0]                  r_k;
    logic                           r_out_valid;
    logic [AW-1:0]                  r_out_addr;
    logic                           r_out_last;
    logic [scp_pkg::COUNT_W-1:0]    r_out_count;

    logic                           acc_fire;
    logic                           rd_en;
    logic                           proc;
    logic                           hit;
    logic                           walk_done;
    logic [CW-1:0]                  total;
    logic                           out_load;
    logic                           k_last;
    logic [DW-1:0]                  n_deg;
    logic [PW-1:0]                  n_head;

    assign i_acc.ready = (r_state == S_IDLE);
    assign acc_fire    = i_acc.valid && (r_state == S_IDLE);

    assign n_deg = (int'(r_cfg_degree) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(r_cfg_degree);

    assign rd_en     = (r_state == S_WALK) && (r_rd_cnt != r_fill);
    assign proc      = (r_state == S_WALK) && r_dv && (r_found != NW'(scp_pkg::CORR_LIMIT));
    assign hit       = (r_rd_data[AW:1] == r_addr);
    assign walk_done = (r_state == S_WALK) &&
                       ((r_found == NW'(scp_pkg::CORR_LIMIT)) ||
                        ((r_rd_cnt == r_fill) && !r_dv));
    assign n_head    = (r_head == PW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign total    = CW'(r_deg) + CW'(r_found);
    assign out_load = (r_state == S_EMIT) && (!r_out_valid || o_pf.ready);
    assign k_last   = (r_k == total - 1'b1);

    assign o_pf.valid            = r_out_valid;
    assign o_pf.prefetch_address = r_out_addr;
    assign o_pf.last_of_run      = r_out_last;
    assign o_pf.issued_count     = r_out_count;

    // history memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
        if (walk_done) begin
            r_mem[r_head] <= {r_addr, r_miss};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_degree <= scp_pkg::DEGREE_RESET;
            r_cfg_line   <= scp_pkg::LINE_RESET;
            r_head       <= '0;
            r_fill       <= '0;
            r_dv         <= 1'b0;
            r_found      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    scp_pkg::CFG_IDX_DEGREE: begin
                        r_cfg_degree <= i_cfg_data[scp_pkg::DEGREE_W-1:0];
                    end
                    scp_pkg::CFG_IDX_LINE: begin
                        r_cfg_line <= i_cfg_data[scp_pkg::LINE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && o_pf.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            r_dv <= rd_en;

            case (r_state)
                S_IDLE: begin
                    if (acc_fire) begin
                        r_addr      <= i_acc.access_address;
                        r_miss      <= i_acc.was_miss;
                        r_deg       <= n_deg;
                        r_seq       <= i_acc.access_address + AW'(r_cfg_line);
                        r_rd_ptr    <= (r_head == '0) ? PW'(HISTORY_DEPTH - 1) : r_head - 1'b1;
                        r_rd_cnt    <= '0;
                        r_follow_ok <= 1'b0;
                        r_follow    <= '0;
                        r_prev_ok   <= 1'b0;
                        r_prev      <= '0;
                        r_found     <= '0;
                        r_state     <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (rd_en) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                        r_rd_ptr <= (r_rd_ptr == '0) ? PW'(HISTORY_DEPTH - 1) : r_rd_ptr - 1'b1;
                    end
                    if (proc) begin
                        if (hit) begin
                            if (r_follow_ok && r_prev_ok && (r_follow == r_prev)) begin
                                if (r_found == '0) begin
                                    r_corr0 <= r_prev;
                                end else begin
                                    r_corr1 <= r_prev;
                                end
                                r_found <= r_found + 1'b1;
                            end
                            r_prev_ok   <= r_follow_ok;
                            r_prev      <= r_follow;
                            r_follow_ok <= 1'b0;
                            r_follow    <= '0;
                        end else if (r_rd_data[0]) begin
                            r_follow_ok <= 1'b1;
                            r_follow    <= r_rd_data[AW:1];
                        end
                    end
                    if (walk_done) begin
                        r_head <= n_head;
                        if (r_fill != FW'(HISTORY_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_k     <= '0;
                        r_state <= (total == '0) ? S_IDLE : S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        if (r_k < CW'(r_deg)) begin
                            r_out_addr <= r_seq;
                            r_seq      <= r_seq + AW'(r_cfg_line);
                        end else if (r_k == CW'(r_deg)) begin
                            r_out_addr <= r_corr0;
                        end else begin
                            r_out_addr <= r_corr1;
                        end
                        r_out_last  <= k_last;
                        r_out_count <= k_last ? scp_pkg::COUNT_W'(total) : '0;
                        r_k         <= r_k + 1'b1;
                        if (k_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // emit index stays inside the run
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_k < total))
        else $error("emit index beyond run length");

    // every finished walk appends one history entry
    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_done |=> ((r_fill == $past(r_fill) + 1'b1) ||
                       ($past(r_fill) == FW'(HISTORY_DEPTH))))
        else $error("history fill count not advanced");

    // the walk never reads more entries than have been written
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_rd_cnt <= r_fill))
        else $error("history walk past written entries");

    // no new access while a run is still being emitted
    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !i_acc.ready)
        else $error("access accepted during emit");

endmodule
